FILE: rtl/mtd_pkg.sv
// Shared types, character codes and lookup functions for the MIME transfer decoder.
package mtd_pkg;

    localparam int BYTE_W     = 8;
    localparam int MAX_OUT    = 3;
    localparam int CNT_W      = 2;
    localparam int ACC_W      = 13;
    localparam int BCNT_W     = 4;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int MODE_W     = 2;

    // register index taken from paddr[2]
    localparam logic REG_DECODE_MODE = 1'b0;

    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [1:0] {
        MODE_PASS   = 2'd0,
        MODE_BASE64 = 2'd1,
        MODE_QP     = 2'd2,
        MODE_QP_HDR = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_EQ    = 3'd1,
        PH_EQCR  = 3'd2,
        PH_EQHEX = 3'd3
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sextet_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } nibble_t;

    typedef struct packed {
        logic [CNT_W-1:0]                 count;
        logic [MAX_OUT-1:0][BYTE_W-1:0]   data;
    } dec_result_t;

    typedef struct packed {
        logic             free;
        logic [CNT_W-1:0] remaining;
    } out_status_t;

    function automatic sextet_t sextet(input logic [7:0] c);
        sextet_t r;
        r = '0;
        if (c inside {[8'h41:8'h5A]}) begin
            r.valid = 1'b1;
            r.value = 6'(c - 8'h41);
        end else if (c inside {[8'h61:8'h7A]}) begin
            r.valid = 1'b1;
            r.value = 6'(c - 8'd71);
        end else if (c inside {[8'h30:8'h39]}) begin
            r.valid = 1'b1;
            r.value = 6'(c + 8'd4);
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            r.valid = 1'b1;
            r.value = 6'd62;
        end else if (c == CH_SLASH || c == CH_UNDER) begin
            r.valid = 1'b1;
            r.value = 6'd63;
        end
        return r;
    endfunction

    function automatic nibble_t nibble(input logic [7:0] c);
        nibble_t r;
        r = '0;
        if (c inside {[8'h30:8'h39]}) begin
            r.valid = 1'b1;
            r.value = 4'(c - 8'h30);
        end else if (c inside {[8'h61:8'h66]}) begin
            r.valid = 1'b1;
            r.value = 4'(c - 8'd87);
        end else if (c inside {[8'h41:8'h46]}) begin
            r.valid = 1'b1;
            r.value = 4'(c - 8'd55);
        end
        return r;
    endfunction

endpackage

FILE: rtl/mtd_decode.sv
// Decode core: escape and base64 state plus the per-byte decode logic.
module mtd_decode (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mtd_pkg::mode_t       mode_i,
    input  logic [7:0]           byte_i,
    input  logic                 end_i,
    input  logic                 advance_i,
    output mtd_pkg::dec_result_t res_o
);
    import mtd_pkg::*;

    phase_t              ph_reg, ph_next;
    logic [7:0]          held_reg, held_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [BCNT_W-1:0]   cnt_reg, cnt_next;
    logic                pad_reg, pad_next;

    dec_result_t         res;
    logic [CNT_W-1:0]    n;
    logic                hdr;
    logic                do_idle;
    sextet_t             sx;
    nibble_t             nb_c;
    nibble_t             nb_h;
    logic [ACC_W-1:0]    acc6;
    logic [BCNT_W-1:0]   cnt6;
    logic [BCNT_W-1:0]   cnt8;
    logic [ACC_W-1:0]    shifted;

    assign hdr  = (mode_i == MODE_QP_HDR);
    assign sx   = sextet(byte_i);
    assign nb_c = nibble(byte_i);
    assign nb_h = nibble(held_reg);
    assign acc6 = {acc_reg[ACC_W-7:0], sx.value};
    assign cnt6 = cnt_reg + BCNT_W'(6);
    assign cnt8 = cnt6 - BCNT_W'(8);
    assign shifted = acc6 >> cnt8;

    always_comb begin
        res       = '0;
        n         = '0;
        do_idle   = 1'b0;
        ph_next   = ph_reg;
        held_next = held_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        pad_next  = pad_reg;

        case (mode_i)
            MODE_PASS: begin
                res.data[n] = byte_i;
                n = n + 1'b1;
            end
            MODE_BASE64: begin
                if (!pad_reg) begin
                    if (byte_i == CH_EQ) begin
                        pad_next = 1'b1;
                    end else if (sx.valid) begin
                        if (cnt6 >= BCNT_W'(8)) begin
                            res.data[n] = shifted[7:0];
                            n = n + 1'b1;
                            cnt_next = cnt8;
                            acc_next = acc6 & ((ACC_W'(1) << cnt8) - ACC_W'(1));
                        end else begin
                            cnt_next = cnt6;
                            acc_next = acc6;
                        end
                    end
                end
            end
            default: begin
                ph_next = PH_IDLE;
                case (ph_reg)
                    PH_EQ: begin
                        if (byte_i == CH_LF) begin
                            // soft line break
                        end else if (byte_i == CH_CR) begin
                            if (!end_i) begin
                                ph_next = PH_EQCR;
                            end
                        end else if (nb_c.valid) begin
                            if (end_i) begin
                                res.data[n] = CH_EQ;
                                n = n + 1'b1;
                                res.data[n] = byte_i;
                                n = n + 1'b1;
                            end else begin
                                held_next = byte_i;
                                ph_next   = PH_EQHEX;
                            end
                        end else begin
                            res.data[n] = CH_EQ;
                            n = n + 1'b1;
                            do_idle = 1'b1;
                        end
                    end
                    PH_EQCR: begin
                        if (byte_i != CH_LF) begin
                            do_idle = 1'b1;
                        end
                    end
                    PH_EQHEX: begin
                        if (nb_h.valid && nb_c.valid) begin
                            res.data[n] = {nb_h.value, nb_c.value};
                            n = n + 1'b1;
                        end else begin
                            // malformed escape: emit it literally, then reparse this byte
                            res.data[n] = CH_EQ;
                            n = n + 1'b1;
                            res.data[n] = (hdr && held_reg == CH_UNDER) ? CH_SPACE : held_reg;
                            n = n + 1'b1;
                            do_idle = 1'b1;
                        end
                    end
                    default: begin
                        do_idle = 1'b1;
                    end
                endcase
                if (do_idle) begin
                    if (byte_i == CH_EQ) begin
                        if (end_i) begin
                            res.data[n] = CH_EQ;
                            n = n + 1'b1;
                        end else begin
                            ph_next = PH_EQ;
                        end
                    end else begin
                        res.data[n] = (hdr && byte_i == CH_UNDER) ? CH_SPACE : byte_i;
                        n = n + 1'b1;
                    end
                end
            end
        endcase

        if (end_i) begin
            ph_next   = PH_IDLE;
            held_next = '0;
            acc_next  = '0;
            cnt_next  = '0;
            pad_next  = 1'b0;
        end
        res.count = n;
    end

    assign res_o = res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg   <= PH_IDLE;
            held_reg <= '0;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            pad_reg  <= 1'b0;
        end else if (advance_i) begin
            ph_reg   <= ph_next;
            held_reg <= held_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            pad_reg  <= pad_next;
        end
    end

endmodule

FILE: rtl/mtd_out_stage.sv
// Result register: holds up to three decoded bytes and shifts them out one per transaction.
module mtd_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load_i,
    input  mtd_pkg::dec_result_t res_i,
    output mtd_pkg::out_status_t status_o,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_out_byte,
    output logic                 m_run_last
);
    import mtd_pkg::*;

    logic [MAX_OUT-1:0][BYTE_W-1:0] buf_reg, buf_next;
    logic [CNT_W-1:0]               rem_reg, rem_next;
    logic                           pop;

    assign m_valid    = (rem_reg != '0);
    assign m_out_byte = buf_reg[0];
    assign m_run_last = (rem_reg == CNT_W'(1));
    assign pop        = m_valid && m_ready;

    assign status_o.free      = (rem_reg == '0) || (m_run_last && m_ready);
    assign status_o.remaining = rem_reg;

    always_comb begin
        buf_next = buf_reg;
        rem_next = rem_reg;
        if (load_i) begin
            buf_next = res_i.data;
            rem_next = res_i.count;
        end else if (pop) begin
            // advance to the next pending byte
            buf_next = {BYTE_W'(0), buf_reg[MAX_OUT-1:1]};
            rem_next = rem_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

endmodule

FILE: rtl/mime_transfer_decoder_top.sv
// Top level of the MIME transfer decoder: config port, input register, decode core, result register.
//
//  channel   ports                                 direction  payload
//  input     s_valid s_ready s_in_byte             in         byte, end flag
//            s_end_of_data
//  result    m_valid m_ready m_out_byte m_run_last out        byte, last-of-input flag
//  config    psel penable pwrite paddr pwdata      in/out     decode_mode at address 0
//            prdata pready
//
// One input byte per cycle while the result side is not stalled and each byte gives at most one
// result; a byte that gives two or three results holds the input while the result register drains.
// Each byte passes through the input register, then the result register.
// Reset is synchronous, active low, and clears mode and all decode state.
// A stalled result side backs up into the input register and then drops s_ready.
module mime_transfer_decoder_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mtd_pkg::PADDR_W-1:0]   paddr,
    input  logic [mtd_pkg::PDATA_W-1:0]   pwdata,
    output logic [mtd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_in_byte,
    input  logic                          s_end_of_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_out_byte,
    output logic                          m_run_last
);
    import mtd_pkg::*;

    mode_t        mode_reg;
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_end_reg;
    dec_result_t  dec_res;
    out_status_t  out_status;
    logic         advance;
    logic         load;
    logic         reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1] == REG_DECODE_MODE);
    assign prdata  = reg_sel ? PDATA_W'(mode_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_PASS;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            mode_reg <= mode_t'(pwdata[MODE_W-1:0]);
        end
    end

    // a byte with no results moves on even while the result register is busy
    assign advance = in_valid_reg && ((dec_res.count == '0) || out_status.free);
    assign load    = advance && (dec_res.count != '0);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            in_end_reg  <= s_end_of_data;
        end
    end

    mtd_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mode_i    (mode_reg),
        .byte_i    (in_byte_reg),
        .end_i     (in_end_reg),
        .advance_i (advance),
        .res_o     (dec_res)
    );

    mtd_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_i     (load),
        .res_i      (dec_res),
        .status_o   (out_status),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_run_last (m_run_last)
    );

`ifndef SYNTH
    a_load_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid && (out_status.remaining == $past(dec_res.count)))
        else $error("loaded results not presented");

    a_held_item_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg)
            && $stable(in_end_reg))
        else $error("pending input item lost");

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_run_last |=> m_valid)
        else $error("result run ended before its last byte");

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> out_status.free)
        else $error("result register overwritten");
`endif

endmodule

FILE: tb/tb_mime_transfer_decoder_top.sv
// Self-checking testbench for the MIME transfer decoder: directed and random bodies in all modes.
`timescale 1ns / 100ps

module tb_mime_transfer_decoder_top;
    import mtd_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       eod;
    } enc_byte_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } dec_byte_t;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte     = '0;
    logic        s_end_of_data = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_run_last;

    enc_byte_t   enc_bytes[$];
    dec_byte_t   decoded_due[$];
    logic [7:0]  step_bytes[$];
    int          errors    = 0;
    int          gap_pct   = 0;
    int          stall_pct = 0;
    int          gap_left  = 0;
    int          stall_left = 0;

    // decoder state as predicted
    mode_t       dec_mode  = MODE_PASS;
    phase_t      esc_phase = PH_IDLE;
    logic [7:0]  esc_held  = '0;
    logic [12:0] b64_bits  = '0;
    logic [3:0]  b64_nbits = '0;
    logic        b64_done  = 1'b0;

    string b64_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/-_";
    string hex_chars = "0123456789ABCDEFabcdef";

    mime_transfer_decoder_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_end_of_data (s_end_of_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_run_last    (m_run_last)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int b64_value(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 'h41;
        if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 'h61 + 26;
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30 + 52;
        if (c == CH_PLUS || c == CH_MINUS) return 62;
        if (c == CH_SLASH || c == CH_UNDER) return 63;
        return -1;
    endfunction

    function automatic int hex_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    function automatic void emit_decoded(input logic [7:0] b);
        if (step_bytes.size() < MAX_OUT) step_bytes.push_back(b);
    endfunction

    // header Q turns only a literal underscore into a space
    function automatic void emit_plain(input logic [7:0] c);
        emit_decoded((dec_mode == MODE_QP_HDR && c == CH_UNDER) ? CH_SPACE : c);
    endfunction

    function automatic void qp_open(input logic [7:0] c, input logic eod);
        if (c == CH_EQ) begin
            if (eod) emit_decoded(CH_EQ);
            else esc_phase = PH_EQ;
        end else begin
            emit_plain(c);
        end
    endfunction

    function automatic void qp_byte(input logic [7:0] c, input logic eod);
        phase_t was;
        int     hi;
        int     lo;
        was = esc_phase;
        esc_phase = PH_IDLE;
        case (was)
            PH_EQ: begin
                if (c == CH_CR) begin
                    if (!eod) esc_phase = PH_EQCR;
                end else if (hex_value(c) >= 0) begin
                    if (eod) begin
                        emit_decoded(CH_EQ);
                        emit_decoded(c);
                    end else begin
                        esc_held = c;
                        esc_phase = PH_EQHEX;
                    end
                end else if (c != CH_LF) begin
                    emit_decoded(CH_EQ);
                    qp_open(c, eod);
                end
            end
            PH_EQCR: begin
                if (c != CH_LF) qp_open(c, eod);
            end
            PH_EQHEX: begin
                hi = hex_value(esc_held);
                lo = hex_value(c);
                if (hi >= 0 && lo >= 0) begin
                    emit_decoded(8'((hi << 4) | lo));
                end else begin
                    // malformed escape goes out literally, new byte starts fresh
                    emit_decoded(CH_EQ);
                    emit_plain(esc_held);
                    qp_open(c, eod);
                end
            end
            default: qp_open(c, eod);
        endcase
    endfunction

    function automatic void b64_byte(input logic [7:0] c);
        int v;
        int acc;
        int n;
        if (!b64_done) begin
            if (c == CH_EQ) begin
                b64_done = 1'b1;
            end else begin
                v = b64_value(c);
                if (v >= 0) begin
                    acc = ((int'(b64_bits) << 6) | v) & 'h1FFF;
                    n = (int'(b64_nbits) + 6) & 'hF;
                    if (n >= 8) begin
                        n -= 8;
                        emit_decoded(8'((acc >> n) & 'hFF));
                        acc &= (1 << n) - 1;
                    end
                    b64_bits = 13'(acc);
                    b64_nbits = 4'(n);
                end
            end
        end
    endfunction

    function automatic void predict_decode(input logic [7:0] c, input logic eod);
        step_bytes.delete();
        case (dec_mode)
            MODE_PASS:   emit_decoded(c);
            MODE_BASE64: b64_byte(c);
            default:     qp_byte(c, eod);
        endcase
        if (eod) begin
            esc_phase = PH_IDLE;
            esc_held  = '0;
            b64_bits  = '0;
            b64_nbits = '0;
            b64_done  = 1'b0;
        end
        foreach (step_bytes[i])
            decoded_due.push_back('{data: step_bytes[i], last: (i == step_bytes.size() - 1)});
    endfunction

    function automatic void note_error();
        errors++;
    endfunction

    // input side: feed queued bytes, with random idle bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else if (!s_valid || s_ready) begin
            if (gap_left != 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
                gap_left = $urandom_range(0, 15);
                s_valid <= 1'b0;
            end else if (enc_bytes.size() != 0) begin
                s_valid       <= 1'b1;
                s_in_byte     <= enc_bytes[0].data;
                s_end_of_data <= enc_bytes[0].eod;
                enc_bytes.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side: predict on each input transaction, check each result transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (s_valid && s_ready) predict_decode(s_in_byte, s_end_of_data);
            if (m_valid && m_ready) begin
                if (decoded_due.size() == 0) begin
                    note_error();
                    $display("%0t: result expected none actual out_byte %02h run_last %0b",
                             $time, m_out_byte, m_run_last);
                end else begin
                    if (m_out_byte !== decoded_due[0].data) begin
                        note_error();
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, decoded_due[0].data, m_out_byte);
                    end
                    if (m_run_last !== decoded_due[0].last) begin
                        note_error();
                        $display("%0t: run_last expected %0b actual %0b",
                                 $time, decoded_due[0].last, m_run_last);
                    end
                    decoded_due.pop_front();
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 15);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic eod);
        enc_bytes.push_back('{data: b, eod: eod});
    endtask

    task automatic push_text(input string s, input logic eod_last);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], eod_last && (i == s.len() - 1));
    endtask

    // hold until every byte is taken and every result is back, then let the pipe settle
    task automatic wait_drained();
        @(negedge aclk);
        while (enc_bytes.size() != 0 || s_valid || decoded_due.size() != 0)
            @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic write_mode(input mode_t m);
        logic [31:0] rd;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_DECODE_MODE, 2'b00};
        pwdata  <= {30'($urandom), m};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        dec_mode = m;
        // read back with a fresh setup phase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[MODE_W-1:0] !== m) begin
            note_error();
            $display("%0t: decode_mode read expected %0d actual %0d", $time, m, rd[MODE_W-1:0]);
        end
        @(negedge aclk);
    endtask

    task automatic queue_body(input mode_t m, input int target);
        logic [7:0] txt[$];
        int         pick;
        int         cut;
        logic       close;
        while (txt.size() < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 8 || m == MODE_PASS) begin
                txt.push_back(8'($urandom));
            end else if (m == MODE_BASE64) begin
                if (pick < 12) txt.push_back(CH_EQ);
                else txt.push_back(b64_chars[$urandom_range(0, 65)]);
            end else if (pick < 45) begin
                txt.push_back(8'($urandom_range(32, 126)));
            end else if (pick < 70) begin
                txt.push_back(CH_EQ);
                txt.push_back(hex_chars[$urandom_range(0, 21)]);
                txt.push_back(hex_chars[$urandom_range(0, 21)]);
            end else if (pick < 78) begin
                txt.push_back(CH_EQ);
                txt.push_back(CH_LF);
            end else if (pick < 86) begin
                txt.push_back(CH_EQ);
                txt.push_back(CH_CR);
                txt.push_back(CH_LF);
            end else if (pick < 92) begin
                txt.push_back(CH_EQ);
                txt.push_back(hex_chars[$urandom_range(0, 21)]);
                txt.push_back(8'($urandom_range(32, 126)));
            end else if (pick < 96) begin
                txt.push_back(CH_UNDER);
            end else begin
                txt.push_back(CH_EQ);
                txt.push_back(CH_CR);
                txt.push_back(8'($urandom_range(32, 126)));
            end
        end
        // cut some bodies short and leave some open across a mode change
        cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, txt.size()) : txt.size();
        close = ($urandom_range(0, 4) != 0);
        for (int i = 0; i < cut; i++)
            push_byte(txt[i], close && (i == cut - 1));
    endtask

    initial begin
        int    n;
        int    phase_items;
        mode_t m;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        gap_pct   = 30;
        stall_pct = 30;

        wait_drained();
        write_mode(MODE_PASS);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);

        wait_drained();
        write_mode(MODE_BASE64);
        push_text("TW-_*=Q", 1'b1);

        wait_drained();
        write_mode(MODE_QP);
        push_text("=41=\n=", 1'b0);
        push_byte(CH_CR, 1'b0);
        push_byte(CH_LF, 1'b0);
        push_text("=4", 1'b1);
        push_text("=", 1'b1);
        push_byte(CH_EQ, 1'b0);
        push_byte(CH_CR, 1'b1);

        wait_drained();
        write_mode(MODE_QP_HDR);
        push_text("_=5F=5_", 1'b1);

        for (int p = 0; p < 7; p++) begin
            wait_drained();
            m = mode_t'($urandom_range(0, 3));
            write_mode(m);
            if (p >= 5) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : 25;
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
            end
            phase_items = 0;
            while (phase_items < 15) begin
                n = $urandom_range(4, 12);
                queue_body(m, n);
                phase_items += n;
            end
        end

        wait_drained();
        repeat (10) @(negedge aclk);
        if (errors == 0)
            $display("tb_mime_transfer_decoder_top OK");
        else
            $display("tb_mime_transfer_decoder_top NOT OK");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("tb_mime_transfer_decoder_top NOT OK");
        $finish;
    end

endmodule

FILE: mime_transfer_decoder_top.f
rtl/mtd_pkg.sv
rtl/mtd_decode.sv
rtl/mtd_out_stage.sv
rtl/mime_transfer_decoder_top.sv
tb/tb_mime_transfer_decoder_top.sv
